FILE: hw/rtl/cbvb_pkg.sv
// ----------------------------------------------------------------------------
// Cluster bounding volume builder package
// Shared widths, reset values, item types and codes.
// ----------------------------------------------------------------------------
package cbvb_pkg;

    localparam int POS_W            = 24;
    localparam int SLOT_W           = 12;
    localparam int DIAG_W           = 25;
    localparam int SQ_W             = 2 * POS_W;
    localparam int ACC_W            = SQ_W + 2;
    localparam int VERTEX_DEPTH_DEF = 4096;

    typedef logic signed [POS_W-1:0] t_coord;

    // x sits in the lowest bits when a vector is packed onto a bus.
    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_vec;

    typedef struct packed {
        t_vec hi;
        t_vec lo;
    } t_box;

    // Handshake from the sequencer to the result unit.
    typedef struct packed {
        logic start;
        logic with_mesh;
    } t_emit_req;

    localparam t_coord POS_MAX = t_coord'(24'sh7FFFFF);
    localparam t_coord POS_MIN = t_coord'(24'sh800000);

    localparam t_vec VEC_POS_MAX = '{z: POS_MAX, y: POS_MAX, x: POS_MAX};
    localparam t_vec VEC_POS_MIN = '{z: POS_MIN, y: POS_MIN, x: POS_MIN};

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_GATHER = 1'b1;

    localparam logic KIND_CLUSTER = 1'b0;
    localparam logic KIND_MESH    = 1'b1;

endpackage

FILE: hw/rtl/cbvb_vertex_mem.sv
// ----------------------------------------------------------------------------
// Vertex store
// Single-port synchronous memory of positions with a registered read.
// ----------------------------------------------------------------------------
module cbvb_vertex_mem
    import cbvb_pkg::*;
#(
    parameter int DEPTH = VERTEX_DEPTH_DEF,
    parameter int AW    = $clog2(VERTEX_DEPTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  t_vec          i_wdata,
    output t_vec          o_rdata
);

    t_vec r_mem [DEPTH];
    t_vec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // The read data holds until the next read, so a stalled gather keeps it.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cbvb_box_accum.sv
// ----------------------------------------------------------------------------
// Box accumulator
// Running per-axis minimum and maximum for the open cluster and the mesh.
// ----------------------------------------------------------------------------
module cbvb_box_accum
    import cbvb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fold_en,
    input  t_vec i_point,
    input  logic i_close_cluster,
    input  logic i_close_mesh,
    output t_box o_cluster_box,
    output t_box o_mesh_box
);

    t_box r_cluster;
    t_box r_mesh;
    t_box n_cluster;
    t_box n_mesh;

    function automatic t_vec f_vmin(input t_vec a, input t_vec b);
        t_vec v;
        v.x = (b.x < a.x) ? b.x : a.x;
        v.y = (b.y < a.y) ? b.y : a.y;
        v.z = (b.z < a.z) ? b.z : a.z;
        return v;
    endfunction

    function automatic t_vec f_vmax(input t_vec a, input t_vec b);
        t_vec v;
        v.x = (b.x > a.x) ? b.x : a.x;
        v.y = (b.y > a.y) ? b.y : a.y;
        v.z = (b.z > a.z) ? b.z : a.z;
        return v;
    endfunction

    // The boxes with the current point folded in, as the results need them.
    always_comb begin
        n_cluster.lo = f_vmin(r_cluster.lo, i_point);
        n_cluster.hi = f_vmax(r_cluster.hi, i_point);
        n_mesh.lo    = f_vmin(r_mesh.lo, i_point);
        n_mesh.hi    = f_vmax(r_mesh.hi, i_point);
    end

    assign o_cluster_box = n_cluster;
    assign o_mesh_box    = n_mesh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster <= '{hi: VEC_POS_MIN, lo: VEC_POS_MAX};
            r_mesh    <= '{hi: VEC_POS_MIN, lo: VEC_POS_MAX};
        end else if (i_fold_en) begin
            if (i_close_cluster) begin
                r_cluster <= '{hi: VEC_POS_MIN, lo: VEC_POS_MAX};
            end else begin
                r_cluster <= n_cluster;
            end
            if (i_close_mesh) begin
                r_mesh <= '{hi: VEC_POS_MIN, lo: VEC_POS_MAX};
            end else begin
                r_mesh <= n_mesh;
            end
        end
    end

endmodule

FILE: hw/rtl/cbvb_box_emit.sv
// ----------------------------------------------------------------------------
// Box result unit
// Squares the extents, takes the integer square root one bit per cycle and
// presents cluster and mesh results through an output register.
// ----------------------------------------------------------------------------
module cbvb_box_emit
    import cbvb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_emit_req    i_req,
    input  t_box         i_cluster_box,
    input  t_box         i_mesh_box,
    output logic         o_busy,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, mid_x, mid_y, mid_z,
    // diagonal_length, then zero padding
    output logic [247:0] m_axis_tdata,
    // box_kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SQ   = 2'd1;
    localparam logic [1:0] E_ROOT = 2'd2;
    localparam logic [1:0] E_LOAD = 2'd3;

    localparam int ROOT_W = ACC_W + 1;
    localparam int PAD_W  = 248 - 9 * POS_W - DIAG_W;

    logic [1:0]        r_state;
    logic [1:0]        r_cnt;
    t_box              r_box;
    t_box              r_mesh_box;
    logic              r_mesh_pend;
    logic              r_kind;
    logic [SQ_W-1:0]   r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ACC_W-1:0]  r_bit;

    logic              r_out_valid;
    t_vec              r_out_lo;
    t_vec              r_out_hi;
    t_vec              r_out_mid;
    logic [DIAG_W-1:0] r_out_diag;
    logic              r_out_kind;
    logic              r_out_last;

    logic [POS_W-1:0]  ext_sel;
    logic [ROOT_W-1:0] trial;
    logic              take;
    logic              out_free;
    t_vec              mid;

    function automatic logic [POS_W-1:0] f_ext(input t_coord hi, input t_coord lo);
        logic signed [POS_W:0] d;
        d = {hi[POS_W-1], hi} - {lo[POS_W-1], lo};
        return d[POS_W-1:0];
    endfunction

    function automatic t_coord f_mid(input t_coord hi, input t_coord lo);
        logic signed [POS_W:0] s;
        s = {hi[POS_W-1], hi} + {lo[POS_W-1], lo};
        return t_coord'(s[POS_W:1]);
    endfunction

    always_comb begin
        case (r_cnt)
            2'd0:    ext_sel = f_ext(r_box.hi.x, r_box.lo.x);
            2'd1:    ext_sel = f_ext(r_box.hi.y, r_box.lo.y);
            2'd2:    ext_sel = f_ext(r_box.hi.z, r_box.lo.z);
            default: ext_sel = '0;
        endcase
    end

    assign trial    = r_root + {1'b0, r_bit};
    assign take     = m_axis_tvalid && m_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign mid.x = f_mid(r_box.hi.x, r_box.lo.x);
    assign mid.y = f_mid(r_box.hi.y, r_box.lo.y);
    assign mid.z = f_mid(r_box.hi.z, r_box.lo.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_cnt       <= '0;
            r_mesh_pend <= 1'b0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_state     <= E_SQ;
                        r_cnt       <= '0;
                        r_mesh_pend <= i_req.with_mesh;
                    end
                end
                E_SQ: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= E_ROOT;
                    end
                end
                E_ROOT: begin
                    if (r_bit[0]) begin
                        r_state <= E_LOAD;
                    end
                end
                E_LOAD: begin
                    if (out_free) begin
                        r_cnt       <= '0;
                        r_mesh_pend <= 1'b0;
                        r_state     <= r_mesh_pend ? E_SQ : E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    // Datapath: squares are registered before they are summed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    r_box      <= i_cluster_box;
                    r_mesh_box <= i_mesh_box;
                    r_kind     <= KIND_CLUSTER;
                end
            end
            E_SQ: begin
                r_prod <= ext_sel * ext_sel;
                if (r_cnt == 2'd0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                if (r_cnt == 2'd3) begin
                    r_rem  <= r_acc + ACC_W'(r_prod);
                    r_root <= '0;
                    r_bit  <= ACC_W'(1) << (ACC_W - 2);
                end
            end
            E_ROOT: begin
                if ({1'b0, r_rem} >= trial) begin
                    r_rem  <= r_rem - trial[ACC_W-1:0];
                    r_root <= (r_root >> 1) + {1'b0, r_bit};
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            E_LOAD: begin
                if (out_free && r_mesh_pend) begin
                    r_box  <= r_mesh_box;
                    r_kind <= KIND_MESH;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == E_LOAD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == E_LOAD && out_free) begin
            r_out_lo   <= r_box.lo;
            r_out_hi   <= r_box.hi;
            r_out_mid  <= mid;
            r_out_diag <= r_root[DIAG_W-1:0];
            r_out_kind <= r_kind;
            r_out_last <= !r_mesh_pend;
        end
    end

    assign o_busy        = (r_state != E_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_diag, r_out_mid, r_out_hi, r_out_lo};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: hw/rtl/cluster_bounding_volume_builder_core.sv
// ----------------------------------------------------------------------------
// Cluster bounding volume builder
// Loads a vertex store, gathers indexed vertices and emits an axis-aligned
// box, centre and diagonal per cluster and for the whole mesh.
// ----------------------------------------------------------------------------
// A write passes through the address state; a gather through the address state,
// the registered read of the vertex memory and the fold state; one item is in
// flight at a time. A closing gather hands its boxes to the result unit, where
// each result goes through four square steps, 25 root iterations one bit a cycle, and a load.
// A further closing gather waits at the fold step while the result unit is busy.
// Reset is synchronous and active low; the vertex store is not cleared.
module cluster_bounding_volume_builder_core
    import cbvb_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex_slot, in_pos_x, in_pos_y, in_pos_z, then zero padding
    input  logic [87:0]  s_axis_tdata,
    // opcode, end_of_mesh
    input  logic [1:0]   s_axis_tuser,
    // end_of_cluster
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, mid_x, mid_y, mid_z,
    // diagonal_length, then zero padding
    output logic [247:0] m_axis_tdata,
    // box_kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]        r_state;
    logic              r_op;
    logic [SLOT_W-1:0] r_slot;
    t_vec              r_pos;
    logic              r_eoc;
    logic              r_eom;

    logic              accept;
    logic [AW-1:0]     addr;
    logic              mem_we;
    logic              mem_re;
    t_vec              rd_vec;
    logic              need_emit;
    logic              emit_busy;
    logic              fold_en;
    t_emit_req         emit_req;
    t_box              cluster_box;
    t_box              mesh_box;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_axis_tuser[0];
            r_eom  <= s_axis_tuser[1];
            r_eoc  <= s_axis_tlast;
            r_slot <= s_axis_tdata[SLOT_W-1:0];
            r_pos  <= t_vec'(s_axis_tdata[SLOT_W +: 3*POS_W]);
        end
    end

    // Slot to store address: the slot wraps modulo the store depth.
    generate
        if (VERTEX_DEPTH >= (1 << SLOT_W)) begin : g_addr_wide
            assign addr = AW'(r_slot);
        end else if ((VERTEX_DEPTH & (VERTEX_DEPTH - 1)) == 0) begin : g_addr_pow2
            assign addr = r_slot[AW-1:0];
        end else begin : g_addr_recip
            localparam int RecipShift = 24;
            localparam longint Recip  = (64'd1 << RecipShift) / VERTEX_DEPTH;
            localparam int RecipW     = $clog2(Recip + 1);
            localparam int ProdW      = SLOT_W + RecipW;
            localparam int QW         = ProdW - RecipShift;
            localparam int DiffW      = SLOT_W + 1;

            logic [ProdW-1:0] r_prod;
            logic [QW-1:0]    quot;
            logic [ProdW-1:0] qd;
            logic [DiffW-1:0] diff;
            logic [DiffW-1:0] rem;

            // The floored reciprocal leaves the quotient at most one short.
            always_ff @(posedge i_clk) begin
                if (accept) begin
                    r_prod <= ProdW'(s_axis_tdata[SLOT_W-1:0]) * ProdW'(Recip);
                end
            end

            assign quot = r_prod[ProdW-1:RecipShift];
            assign qd   = ProdW'(quot) * ProdW'(VERTEX_DEPTH);
            assign diff = DiffW'(r_slot) - qd[DiffW-1:0];
            assign rem  = (diff >= DiffW'(VERTEX_DEPTH)) ? diff - DiffW'(VERTEX_DEPTH) : diff;
            assign addr = rem[AW-1:0];
        end
    endgenerate

    assign mem_we    = (r_state == ST_ADDR) && (r_op == OP_WRITE);
    assign mem_re    = (r_state == ST_ADDR) && (r_op == OP_GATHER);
    assign need_emit = r_eoc || r_eom;
    assign fold_en   = (r_state == ST_FOLD) && (!need_emit || !emit_busy);

    assign emit_req.start     = fold_en && need_emit;
    assign emit_req.with_mesh = r_eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= (r_op == OP_GATHER) ? ST_FOLD : ST_IDLE;
                end
                ST_FOLD: begin
                    if (fold_en) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    cbvb_vertex_mem #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (addr),
        .i_wdata (r_pos),
        .o_rdata (rd_vec)
    );

    cbvb_box_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fold_en       (fold_en),
        .i_point         (rd_vec),
        .i_close_cluster (need_emit),
        .i_close_mesh    (r_eom),
        .o_cluster_box   (cluster_box),
        .o_mesh_box      (mesh_box)
    );

    cbvb_box_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (emit_req),
        .i_cluster_box (cluster_box),
        .i_mesh_box    (mesh_box),
        .o_busy        (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: sim/cbvb_box_checker.sv
// ----------------------------------------------------------------------------
// Cluster bounding volume builder checker
// Watches both stream channels of the block. It keeps its own copy of the
// vertex store and of the running cluster and mesh bounds, works out the
// boxes that each gather transaction closes, and compares every result
// transaction field by field with the oldest box still due.
// ----------------------------------------------------------------------------
module cbvb_box_checker
    import cbvb_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    // vertex_slot, in_pos_x, in_pos_y, in_pos_z, then zero padding
    input  logic [87:0]  i_s_axis_tdata,
    // opcode, end_of_mesh
    input  logic [1:0]   i_s_axis_tuser,
    // end_of_cluster
    input  logic         i_s_axis_tlast,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, mid_x, mid_y, mid_z,
    // diagonal_length, then zero padding
    input  logic [247:0] i_m_axis_tdata,
    // box_kind
    input  logic         i_m_axis_tuser,
    input  logic         i_m_axis_tlast,
    output int           o_mismatch_count,
    output int           o_results_pending
);

    localparam int MAX_PRINTED = 60;

    typedef struct packed {
        logic              kind;
        t_vec              lo;
        t_vec              hi;
        t_vec              mid;
        logic [DIAG_W-1:0] diag;
        logic              last;
    } t_box_result;

    t_vec        vertex_mem [VERTEX_DEPTH];
    t_vec        cluster_lo = VEC_POS_MAX;
    t_vec        cluster_hi = VEC_POS_MIN;
    t_vec        mesh_lo    = VEC_POS_MAX;
    t_vec        mesh_hi    = VEC_POS_MIN;
    t_box_result boxes_due [$];
    int          results_seen = 0;
    int          mismatches   = 0;

    initial o_results_pending = 0;
    assign o_mismatch_count = mismatches;

    function automatic t_vec axis_min(t_vec a, t_vec b);
        t_vec r;
        r.x = (b.x < a.x) ? b.x : a.x;
        r.y = (b.y < a.y) ? b.y : a.y;
        r.z = (b.z < a.z) ? b.z : a.z;
        return r;
    endfunction

    function automatic t_vec axis_max(t_vec a, t_vec b);
        t_vec r;
        r.x = (b.x > a.x) ? b.x : a.x;
        r.y = (b.y > a.y) ? b.y : a.y;
        r.z = (b.z > a.z) ? b.z : a.z;
        return r;
    endfunction

    // Largest root whose square does not exceed n, settled one bit at a time.
    function automatic logic [DIAG_W-1:0] floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = DIAG_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root[DIAG_W-1:0];
    endfunction

    function automatic t_box_result bound_box(logic kind, t_vec lo, t_vec hi, logic last);
        t_box_result     r;
        t_coord          l;
        t_coord          h;
        logic signed [POS_W:0] sum;
        longint          ext;
        longint unsigned sq;
        sq = 0;
        r.kind = kind;
        r.lo   = lo;
        r.hi   = hi;
        r.last = last;
        for (int a = 0; a < 3; a++) begin
            l   = lo[a*POS_W +: POS_W];
            h   = hi[a*POS_W +: POS_W];
            sum = l + h;
            // Dropping the low bit of the signed sum rounds toward minus infinity.
            r.mid[a*POS_W +: POS_W] = sum[POS_W:1];
            ext = longint'(h) - longint'(l);
            sq  = sq + longint'(ext * ext);
        end
        r.diag = floor_sqrt(sq);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : predict_and_compare
        int unsigned slot;
        t_vec        p;
        t_box_result got;
        t_box_result want;
        logic        eoc;
        logic        eom;
        if (!i_rst_n) begin
            cluster_lo = VEC_POS_MAX;
            cluster_hi = VEC_POS_MIN;
            mesh_lo    = VEC_POS_MAX;
            mesh_hi    = VEC_POS_MIN;
        end else begin
            // A result always trails its gather, so the output side is settled
            // before this edge's input transaction is folded in.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.kind = i_m_axis_tuser;
                got.lo   = i_m_axis_tdata[71:0];
                got.hi   = i_m_axis_tdata[143:72];
                got.mid  = i_m_axis_tdata[215:144];
                got.diag = i_m_axis_tdata[240:216];
                got.last = i_m_axis_tlast;
                if (boxes_due.size() == 0) begin
                    report_mismatch("result transaction with no box due");
                end else begin
                    want = boxes_due.pop_front();
                    check_field("box_kind", got.kind, want.kind);
                    check_field("last_result", got.last, want.last);
                    // Axis letters x, y and z are consecutive character codes.
                    for (int a = 0; a < 3; a++) begin
                        check_field($sformatf("lo_%c", 8'h78 + a),
                                    $signed(got.lo[a*POS_W +: POS_W]),
                                    $signed(want.lo[a*POS_W +: POS_W]));
                        check_field($sformatf("hi_%c", 8'h78 + a),
                                    $signed(got.hi[a*POS_W +: POS_W]),
                                    $signed(want.hi[a*POS_W +: POS_W]));
                        check_field($sformatf("mid_%c", 8'h78 + a),
                                    $signed(got.mid[a*POS_W +: POS_W]),
                                    $signed(want.mid[a*POS_W +: POS_W]));
                    end
                    check_field("diagonal_length", got.diag, want.diag);
                    check_field("tdata padding", i_m_axis_tdata[247:241], 0);
                end
                results_seen++;
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                slot = i_s_axis_tdata[SLOT_W-1:0] % VERTEX_DEPTH;
                if (i_s_axis_tuser[0] == OP_WRITE) begin
                    vertex_mem[slot] = i_s_axis_tdata[SLOT_W +: 3*POS_W];
                end else begin
                    p          = vertex_mem[slot];
                    cluster_lo = axis_min(cluster_lo, p);
                    cluster_hi = axis_max(cluster_hi, p);
                    mesh_lo    = axis_min(mesh_lo, p);
                    mesh_hi    = axis_max(mesh_hi, p);
                    eoc        = i_s_axis_tlast;
                    eom        = i_s_axis_tuser[1];
                    // A mesh end closes the open cluster as well.
                    if (eoc || eom) begin
                        boxes_due.push_back(bound_box(KIND_CLUSTER, cluster_lo, cluster_hi, !eom));
                        cluster_lo = VEC_POS_MAX;
                        cluster_hi = VEC_POS_MIN;
                    end
                    if (eom) begin
                        boxes_due.push_back(bound_box(KIND_MESH, mesh_lo, mesh_hi, 1'b1));
                        mesh_lo = VEC_POS_MAX;
                        mesh_hi = VEC_POS_MIN;
                    end
                end
            end
        end
        o_results_pending <= boxes_due.size();
    end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Cluster bounding volume builder testbench
// Loads the vertex store, then sends gather transactions grouped into
// clusters and meshes: a short directed part for the coordinate extremes and
// the closing cases, then random meshes with stray writes and early closes.
// Both channels idle at random and the receiver holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_top;
    import cbvb_pkg::*;

    localparam int ITEM_TARGET     = 1750;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [247:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    int mismatch_count;
    int results_pending;
    int items_sent   = 0;
    bit quiet_send   = 1'b0;
    bit quiet_sink   = 1'b0;
    bit hold_off_req = 1'b0;

    bit                slot_written [1 << SLOT_W];
    logic [SLOT_W-1:0] written_slots [$];

    cluster_bounding_volume_builder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cbvb_box_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_axis_tvalid   (s_axis_tvalid),
        .i_s_axis_tready   (s_axis_tready),
        .i_s_axis_tdata    (s_axis_tdata),
        .i_s_axis_tuser    (s_axis_tuser),
        .i_s_axis_tlast    (s_axis_tlast),
        .i_m_axis_tvalid   (m_axis_tvalid),
        .i_m_axis_tready   (m_axis_tready),
        .i_m_axis_tdata    (m_axis_tdata),
        .i_m_axis_tuser    (m_axis_tuser),
        .i_m_axis_tlast    (m_axis_tlast),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return POS_MAX;
        if (r < 16)
            return POS_MIN;
        if (r < 45)
            return t_coord'(int'($urandom_range(0, 4095)) - 2048);
        return t_coord'($urandom);
    endfunction

    function automatic t_vec rand_vec();
        t_vec v;
        v.x = rand_coord();
        v.y = rand_coord();
        v.z = rand_coord();
        return v;
    endfunction

    function automatic logic [SLOT_W-1:0] any_written();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    // Overwrites of slots already in use are mixed in with fresh slots.
    function automatic logic [SLOT_W-1:0] pick_write_slot();
        if (written_slots.size() != 0 && $urandom_range(0, 9) < 3)
            return any_written();
        return SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
    endfunction

    task automatic offer_item(logic op, logic [SLOT_W-1:0] slot, t_vec pos,
                              logic eoc, logic eom);
        int gap;
        gap = pick_gap(quiet_send);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pos, slot};
        s_axis_tuser  <= {eom, op};
        s_axis_tlast  <= eoc;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic store_vertex(logic [SLOT_W-1:0] slot, t_vec pos, logic eoc, logic eom);
        offer_item(OP_WRITE, slot, pos, eoc, eom);
        if (!slot_written[slot]) begin
            slot_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
    endtask

    // The position bits of a gather are don't-care, so they carry noise.
    task automatic gather(logic [SLOT_W-1:0] slot, logic eoc, logic eom);
        offer_item(OP_GATHER, slot, rand_vec(), eoc, eom);
    endtask

    task automatic store_random();
        store_vertex(pick_write_slot(), rand_vec(), 1'($urandom), 1'($urandom));
    endtask

    task automatic build_mesh();
        int   n_writes;
        int   n_clusters;
        int   n_idx;
        logic eoc;
        logic eom;
        n_writes = $urandom_range(1, 20);
        repeat (n_writes) store_random();
        n_clusters = $urandom_range(1, 6);
        for (int c = 0; c < n_clusters; c++) begin
            n_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < n_idx; i++) begin
                if ($urandom_range(0, 19) == 0)
                    store_random();
                eoc = (i == n_idx - 1);
                eom = eoc && (c == n_clusters - 1);
                if (eom) begin
                    eoc = 1'($urandom);
                end else if ($urandom_range(0, 29) == 0) begin
                    // Broken sequence: a cluster or the mesh closes early.
                    eoc = 1'b1;
                    eom = 1'($urandom);
                end
                gather(any_written(), eoc, eom);
            end
        end
    endtask

    initial begin : receiver
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            n = pick_gap(quiet_sink);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int mesh_no;
        int next_hold;
        mesh_no       = 0;
        next_hold     = 300;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Coordinate extremes, with end flags on writes that must be ignored.
        store_vertex(12'h000, VEC_POS_MAX, 1'b0, 1'b0);
        store_vertex(12'hFFF, VEC_POS_MIN, 1'b1, 1'b1);
        store_vertex(12'hAAA, '{z: 24'sd1, y: -24'sd1, x: 24'sd0}, 1'b1, 1'b0);
        store_vertex(12'h555, '{z: -24'sd256, y: 24'sd0, x: 24'sd1}, 1'b0, 1'b1);
        // Single-vertex clusters at both ends of the range.
        gather(12'h000, 1'b1, 1'b0);
        gather(12'hFFF, 1'b1, 1'b0);
        // Full extent on every axis gives the largest diagonal.
        gather(12'h000, 1'b0, 1'b0);
        gather(12'hFFF, 1'b1, 1'b0);
        // Odd negative sums check that the centre rounds downwards.
        gather(12'hAAA, 1'b0, 1'b0);
        gather(12'h555, 1'b1, 1'b0);
        // Mesh end without a cluster end, then both ends together.
        gather(12'hAAA, 1'b0, 1'b1);
        gather(12'h555, 1'b1, 1'b1);
        store_vertex(12'h000, '{z: POS_MAX - 24'sd1, y: 24'sd3, x: -24'sd2}, 1'b0, 1'b0);
        gather(12'h000, 1'b0, 1'b1);
        gather(12'hFFF, 1'b0, 1'b0);
        gather(12'h555, 1'b1, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            // Long receiver hold-offs while the sender keeps offering.
            if (items_sent >= next_hold) begin
                hold_off_req = 1'b1;
                quiet_send   = 1'b1;
                next_hold    = next_hold + 800;
            end else begin
                quiet_send = (mesh_no % 10 == 5);
            end
            quiet_sink = (mesh_no % 10 == 5);
            build_mesh();
            mesh_no++;
        end
        quiet_send = 1'b0;
        quiet_sink = 1'b0;
        s_axis_tvalid <= 1'b0;

        // The checker's pending count is registered, so let it take in the
        // last transaction before looking at it.
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cbvb_pkg.sv
hw/rtl/cbvb_vertex_mem.sv
hw/rtl/cbvb_box_accum.sv
hw/rtl/cbvb_box_emit.sv
hw/rtl/cluster_bounding_volume_builder_core.sv
sim/cbvb_box_checker.sv
sim/tb_top.sv
